// ----- sv/bnkdec_pkg.sv -----
package bnkdec_pkg;

  localparam int WORK_RAM_ADDR_BITS = 13;
  localparam int PAGE_OFFSET_BITS   = 13;
  localparam int BRAM_ADDR_BITS     = 13;
  localparam int CLR_BITS           = (WORK_RAM_ADDR_BITS > BRAM_ADDR_BITS) ?
                                      WORK_RAM_ADDR_BITS : BRAM_ADDR_BITS;

  localparam int LA_W    = 16;
  localparam int PAGE_W  = 8;
  localparam int SLOT_W  = 3;
  localparam int PA_W    = PAGE_W + PAGE_OFFSET_BITS;
  localparam int DATA_W  = 8;
  localparam int REG_W   = 3;
  localparam int NUM_SLOTS = 8;

  localparam logic [PA_W-1:0] ROM_END    = 21'h100000;
  localparam logic [PA_W-1:0] BRAM_BASE  = 21'h1ee000;
  localparam logic [PA_W-1:0] WRAM_BASE  = 21'h1f0000;
  localparam logic [PA_W-1:0] WRAM_END   = 21'h1f8000;
  localparam logic [PA_W-1:0] VIDEO_BASE = 21'h1fe000;
  localparam logic [PA_W-1:0] COLOR_BASE = 21'h1fe400;
  localparam logic [PA_W-1:0] SOUND_BASE = 21'h1fe800;
  localparam logic [PA_W-1:0] TIMER_BASE = 21'h1fec00;
  localparam logic [PA_W-1:0] JOY_BASE   = 21'h1ff000;
  localparam logic [PA_W-1:0] IRQ_BASE   = 21'h1ff400;
  localparam logic [PA_W-1:0] IRQ_END    = 21'h1ff800;

  localparam logic [DATA_W-1:0] OPEN_BUS = 8'hff;
  localparam logic [PAGE_W-1:0] PAGE_RESET     = 8'hff;
  localparam logic [PAGE_W-1:0] PAGE_RESET_TOP = 8'h00;

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_PAGE  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    TGT_LOCAL  = 4'd0,
    TGT_ROM    = 4'd1,
    TGT_VIDEO  = 4'd2,
    TGT_COLOR  = 4'd3,
    TGT_TIMER  = 4'd4,
    TGT_JOYPAD = 4'd5,
    TGT_IRQ    = 4'd6
  } tgt_e;

  typedef enum logic [1:0] {
    RSEL_CONST = 2'd0,
    RSEL_WRAM  = 2'd1,
    RSEL_BRAM  = 2'd2
  } rsel_e;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    rsel_e             rsel;
    tgt_e              target;
    logic [PA_W-1:0]   pa;
    logic [REG_W-1:0]  dev_reg;
    logic [DATA_W-1:0] fwd_data;
    logic              fwd_wr;
    logic              wram_wr;
    logic              bram_wr;
  } dec_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    tgt_e              target;
    logic [PA_W-1:0]   pa;
    logic [REG_W-1:0]  dev_reg;
    logic [DATA_W-1:0] fwd_data;
    logic              fwd_wr;
  } res_t;

endpackage

// ----- sv/bnkdec_ram.sv -----
module bnkdec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/bnkdec_decoder.sv -----
module bnkdec_decoder import bnkdec_pkg::*; (
  input  logic [1:0]        mode_i,
  input  logic [LA_W-1:0]   logical_address_i,
  input  logic [DATA_W-1:0] write_data_i,
  input  logic [PAGE_W-1:0] page_i,
  input  logic              bram_en_i,
  output dec_t              dec_o
);

  mode_e           mode;
  logic            wr;
  logic [PA_W-1:0] pa;
  logic [DATA_W-1:0] unmapped;
  logic [DATA_W-1:0] fwd_wd;

  assign mode     = mode_e'(mode_i);
  assign wr       = (mode == MODE_WRITE);
  assign pa       = {page_i, logical_address_i[PAGE_OFFSET_BITS-1:0]};
  assign unmapped = wr ? '0 : OPEN_BUS;
  assign fwd_wd   = wr ? write_data_i : '0;

  always_comb begin
    dec_o = '0;
    unique case (mode) inside
      MODE_READ, MODE_WRITE: begin
        dec_o.pa = pa;
        if (pa < ROM_END) begin
          dec_o.target   = TGT_ROM;
          dec_o.fwd_data = fwd_wd;
          dec_o.fwd_wr   = wr;
        end else if (pa < BRAM_BASE) begin
          dec_o.read_data = unmapped;
        end else if (pa < WRAM_BASE) begin
          if (!bram_en_i) begin
            dec_o.read_data = unmapped;
          end else if (wr) begin
            dec_o.bram_wr = 1'b1;
          end else begin
            dec_o.rsel = RSEL_BRAM;
          end
        end else if (pa < WRAM_END) begin
          if (wr) begin
            dec_o.wram_wr = 1'b1;
          end else begin
            dec_o.rsel = RSEL_WRAM;
          end
        end else if (pa < VIDEO_BASE) begin
          dec_o.read_data = unmapped;
        end else if (pa < COLOR_BASE) begin
          // Video register 1 is answered locally with zero.
          if (pa[1:0] != 2'd1) begin
            dec_o.target   = TGT_VIDEO;
            dec_o.dev_reg  = {1'b0, pa[1:0]};
            dec_o.fwd_data = fwd_wd;
            dec_o.fwd_wr   = wr;
          end
        end else if (pa < SOUND_BASE) begin
          if (wr ? (pa[2:0] == 3'd0 || (pa[2:0] >= 3'd2 && pa[2:0] <= 3'd5))
                 : (pa[2:0] == 3'd4 || pa[2:0] == 3'd5)) begin
            dec_o.target   = TGT_COLOR;
            dec_o.dev_reg  = pa[2:0];
            dec_o.fwd_data = fwd_wd;
            dec_o.fwd_wr   = wr;
          end
        end else if (pa < TIMER_BASE) begin
          dec_o.read_data = unmapped;
        end else if (pa < JOY_BASE) begin
          // Timer reads always return the counter register.
          dec_o.target   = TGT_TIMER;
          dec_o.dev_reg  = {2'b00, wr & pa[0]};
          dec_o.fwd_data = fwd_wd;
          dec_o.fwd_wr   = wr;
        end else if (pa < IRQ_BASE) begin
          dec_o.target   = TGT_JOYPAD;
          dec_o.fwd_data = fwd_wd;
          dec_o.fwd_wr   = wr;
        end else if (pa < IRQ_END) begin
          if (pa[1]) begin
            dec_o.target   = TGT_IRQ;
            dec_o.dev_reg  = {1'b0, pa[1:0]};
            dec_o.fwd_data = fwd_wd;
            dec_o.fwd_wr   = wr;
          end
        end else begin
          dec_o.read_data = unmapped;
        end
      end
      MODE_PAGE, MODE_NOP: begin
        dec_o = '0;
      end
      default: begin
        dec_o = '0;
      end
    endcase
  end

endmodule

// ----- sv/banked_address_decoder_top.sv -----
// A request accepted at the input is held in the pending register, then moves to the output register.
// Throughput: one request per cycle while in_stall_o is low; the single-port RAM access per request sets it.
// Reset: page slots 0-6 return to 0xFF and slot 7 to 0x00, backup RAM is disabled.
// After reset a clearing pass zeroes both RAMs, one entry per cycle over all
// 2**CLR_BITS (8192) entries; in_stall_o stays high until it completes.
module banked_address_decoder_top import bnkdec_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                backup_ram_enable_we_i,
  input  logic                backup_ram_enable_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          mode_i,
  input  logic [LA_W-1:0]     logical_address_i,
  input  logic [DATA_W-1:0]   write_data_i,
  input  logic [SLOT_W-1:0]   page_slot_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [DATA_W-1:0]   read_data_o,
  output logic [3:0]          target_o,
  output logic [PA_W-1:0]     physical_address_o,
  output logic [REG_W-1:0]    device_register_o,
  output logic [DATA_W-1:0]   forward_data_o,
  output logic                forward_is_write_o
);

  logic                bram_en_q;
  logic [PAGE_W-1:0]   page_q [NUM_SLOTS];
  logic                clear_q;
  logic [CLR_BITS-1:0] clr_cnt_q;
  logic                pend_vld_q, pend_vld_d;
  dec_t                pend_q;
  logic                out_vld_q, out_vld_d;
  res_t                out_q, out_d;

  dec_t                dec;
  logic                accept;
  logic                out_free;
  logic                move;
  logic                wram_we, wram_re, bram_we, bram_re;
  logic [WORK_RAM_ADDR_BITS-1:0] wram_addr;
  logic [BRAM_ADDR_BITS-1:0]     bram_addr;
  logic [DATA_W-1:0]   wram_wdata, bram_wdata;
  logic [DATA_W-1:0]   wram_rdata, bram_rdata;

  bnkdec_decoder u_decoder (
    .mode_i            (mode_i),
    .logical_address_i (logical_address_i),
    .write_data_i      (write_data_i),
    .page_i            (page_q[logical_address_i[LA_W-1 -: SLOT_W]]),
    .bram_en_i         (bram_en_q),
    .dec_o             (dec)
  );

  // A pending request waits only if the output register is full and stalled.
  // Holding off new requests then also keeps the RAM read data stable.
  assign out_free   = !out_vld_q || !out_stall_i;
  assign in_stall_o = clear_q || (pend_vld_q && !out_free);
  assign accept     = in_valid_i && !in_stall_o;
  assign move       = pend_vld_q && out_free;

  // Writes land at the accept edge, so a read of the same entry in the next
  // cycle already sees the new byte.
  assign wram_we    = clear_q || (accept && dec.wram_wr);
  assign bram_we    = clear_q || (accept && dec.bram_wr);
  assign wram_re    = accept && (dec.rsel == RSEL_WRAM);
  assign bram_re    = accept && (dec.rsel == RSEL_BRAM);
  assign wram_addr  = clear_q ? clr_cnt_q[WORK_RAM_ADDR_BITS-1:0]
                              : dec.pa[WORK_RAM_ADDR_BITS-1:0];
  assign bram_addr  = clear_q ? clr_cnt_q[BRAM_ADDR_BITS-1:0]
                              : dec.pa[BRAM_ADDR_BITS-1:0];
  assign wram_wdata = clear_q ? '0 : write_data_i;
  assign bram_wdata = clear_q ? '0 : write_data_i;

  bnkdec_ram #(
    .WIDTH (DATA_W),
    .DEPTH (2 ** WORK_RAM_ADDR_BITS)
  ) u_work_ram (
    .clk_i   (clk_i),
    .we_i    (wram_we),
    .re_i    (wram_re),
    .addr_i  (wram_addr),
    .wdata_i (wram_wdata),
    .rdata_o (wram_rdata)
  );

  bnkdec_ram #(
    .WIDTH (DATA_W),
    .DEPTH (2 ** BRAM_ADDR_BITS)
  ) u_backup_ram (
    .clk_i   (clk_i),
    .we_i    (bram_we),
    .re_i    (bram_re),
    .addr_i  (bram_addr),
    .wdata_i (bram_wdata),
    .rdata_o (bram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bram_en_q <= 1'b0;
    end else if (backup_ram_enable_we_i) begin
      bram_en_q <= backup_ram_enable_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS - 1; i++) begin
        page_q[i] <= PAGE_RESET;
      end
      page_q[NUM_SLOTS-1] <= PAGE_RESET_TOP;
    end else if (accept && (mode_e'(mode_i) == MODE_PAGE)) begin
      page_q[page_slot_i] <= write_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q   <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clear_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (&clr_cnt_q) begin
        clear_q <= 1'b0;
      end
    end
  end

  always_comb begin
    pend_vld_d = pend_vld_q;
    if (accept) begin
      pend_vld_d = 1'b1;
    end else if (move) begin
      pend_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_d           = out_q;
    out_vld_d       = out_vld_q && out_stall_i;
    if (move) begin
      out_vld_d       = 1'b1;
      out_d.target    = pend_q.target;
      out_d.pa        = pend_q.pa;
      out_d.dev_reg   = pend_q.dev_reg;
      out_d.fwd_data  = pend_q.fwd_data;
      out_d.fwd_wr    = pend_q.fwd_wr;
      case (pend_q.rsel)
        RSEL_WRAM: out_d.read_data = wram_rdata;
        RSEL_BRAM: out_d.read_data = bram_rdata;
        default:   out_d.read_data = pend_q.read_data;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_q <= dec;
    end
    out_q <= out_d;
  end

  assign out_valid_o        = out_vld_q;
  assign read_data_o        = out_q.read_data;
  assign target_o           = out_q.target;
  assign physical_address_o = out_q.pa;
  assign device_register_o  = out_q.dev_reg;
  assign forward_data_o     = out_q.fwd_data;
  assign forward_is_write_o = out_q.fwd_wr;

  a_out_from_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(pend_vld_q))
    else $error("result appeared without a pending request");

  a_rdata_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_vld_q && !out_free) |-> !(wram_re || bram_re))
    else $error("RAM read issued while a pending result waits for its data");

  a_clear_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clear_q) |-> $past(&clr_cnt_q))
    else $error("clearing pass ended early");

  a_fwd_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_q.target != TGT_LOCAL)) |-> (out_q.read_data == '0))
    else $error("forwarded request carries local read data");

endmodule

// ----- tb/tb_banked_address_decoder_top.sv -----
`timescale 1ns / 100ps

module tb_banked_address_decoder_top;
  import bnkdec_pkg::*;

  localparam int WATCHDOG_LIMIT = 30000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 410;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                backup_ram_enable_we_i = 1'b0;
  logic                backup_ram_enable_wdata_i = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [1:0]          mode_i = MODE_READ;
  logic [LA_W-1:0]     logical_address_i = '0;
  logic [DATA_W-1:0]   write_data_i = '0;
  logic [SLOT_W-1:0]   page_slot_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [DATA_W-1:0]   read_data_o;
  logic [3:0]          target_o;
  logic [PA_W-1:0]     physical_address_o;
  logic [REG_W-1:0]    device_register_o;
  logic [DATA_W-1:0]   forward_data_o;
  logic                forward_is_write_o;

  int   send_idle_pct = 0;
  int   stall_pct = 0;
  logic hold_off = 1'b0;
  int   stuck_cycles;

  class access_scoreboard;
    bit         backup_enable;
    logic [7:0] page_regs [NUM_SLOTS];
    logic [7:0] work_ram [2**WORK_RAM_ADDR_BITS];
    logic [7:0] backup_ram [2**BRAM_ADDR_BITS];
    res_t       pending_results [$];
    int         mismatches;
    int         n_checked;
    int         n_reads;
    int         n_writes;
    int         n_pages;
    int         n_nops;
    int         n_forwarded;

    function new();
      for (int i = 0; i < NUM_SLOTS; i++)
        page_regs[i] = (i == NUM_SLOTS - 1) ? PAGE_RESET_TOP : PAGE_RESET;
      foreach (work_ram[i]) work_ram[i] = '0;
      foreach (backup_ram[i]) backup_ram[i] = '0;
    endfunction

    function res_t forwarded(tgt_e t, logic [PA_W-1:0] pa, logic [REG_W-1:0] idx,
                             logic wr, logic [DATA_W-1:0] wd);
      res_t r;
      r = '0;
      r.target = t;
      r.pa = pa;
      r.dev_reg = idx;
      r.fwd_data = wr ? wd : '0;
      r.fwd_wr = wr;
      return r;
    endfunction

    // Translates one bus access and applies its side effects on the page
    // registers and the two RAMs.
    function res_t decode_access(mode_e m, logic [LA_W-1:0] la, logic [DATA_W-1:0] wd,
                                 logic [SLOT_W-1:0] slot);
      res_t            r;
      logic [PA_W-1:0] pa;
      logic            wr;
      logic [2:0]      sub;
      logic            pass_on;
      r = '0;
      if (m == MODE_PAGE) begin
        page_regs[slot] = wd;
        return r;
      end
      if (m == MODE_NOP) return r;
      wr = (m == MODE_WRITE);
      pa = {page_regs[la[LA_W-1:PAGE_OFFSET_BITS]], la[PAGE_OFFSET_BITS-1:0]};
      r.pa = pa;
      sub = pa[2:0];
      if (pa < ROM_END) begin
        r = forwarded(TGT_ROM, pa, '0, wr, wd);
      end else if (pa < BRAM_BASE) begin
        r.read_data = wr ? '0 : OPEN_BUS;
      end else if (pa < WRAM_BASE) begin
        if (!backup_enable) r.read_data = wr ? '0 : OPEN_BUS;
        else if (wr) backup_ram[pa[BRAM_ADDR_BITS-1:0]] = wd;
        else r.read_data = backup_ram[pa[BRAM_ADDR_BITS-1:0]];
      end else if (pa < WRAM_END) begin
        if (wr) work_ram[pa[WORK_RAM_ADDR_BITS-1:0]] = wd;
        else r.read_data = work_ram[pa[WORK_RAM_ADDR_BITS-1:0]];
      end else if (pa < VIDEO_BASE) begin
        r.read_data = wr ? '0 : OPEN_BUS;
      end else if (pa < COLOR_BASE) begin
        if (sub[1:0] != 2'd1) r = forwarded(TGT_VIDEO, pa, {1'b0, sub[1:0]}, wr, wd);
      end else if (pa < SOUND_BASE) begin
        // Reads only reach the two data ports; writes skip 1, 6 and 7.
        pass_on = wr ? (sub == 3'd0 || (sub >= 3'd2 && sub <= 3'd5))
                     : (sub == 3'd4 || sub == 3'd5);
        if (pass_on) r = forwarded(TGT_COLOR, pa, sub, wr, wd);
      end else if (pa < TIMER_BASE) begin
        r.read_data = wr ? '0 : OPEN_BUS;
      end else if (pa < JOY_BASE) begin
        r = forwarded(TGT_TIMER, pa, wr ? {2'b00, sub[0]} : 3'd0, wr, wd);
      end else if (pa < IRQ_BASE) begin
        r = forwarded(TGT_JOYPAD, pa, '0, wr, wd);
      end else if (pa < IRQ_END) begin
        if (sub[1:0] >= 2'd2) r = forwarded(TGT_IRQ, pa, {1'b0, sub[1:0]}, wr, wd);
      end else begin
        r.read_data = wr ? '0 : OPEN_BUS;
      end
      return r;
    endfunction

    function void note_access(mode_e m, logic [LA_W-1:0] la, logic [DATA_W-1:0] wd,
                              logic [SLOT_W-1:0] slot);
      res_t r;
      r = decode_access(m, la, wd, slot);
      pending_results.push_back(r);
      case (m)
        MODE_READ:  n_reads++;
        MODE_WRITE: n_writes++;
        MODE_PAGE:  n_pages++;
        default:    n_nops++;
      endcase
      if (r.target != TGT_LOCAL) n_forwarded++;
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with no request pending, pa %06h", got.pa));
        return;
      end
      want = pending_results.pop_front();
      n_checked++;
      if (got.read_data !== want.read_data)
        report_mismatch($sformatf("pa %06h read_data exp %02h got %02h",
                                  want.pa, want.read_data, got.read_data));
      if (got.target !== want.target)
        report_mismatch($sformatf("pa %06h target exp %0d got %0d",
                                  want.pa, want.target, got.target));
      if (got.pa !== want.pa)
        report_mismatch($sformatf("physical_address exp %06h got %06h", want.pa, got.pa));
      if (got.dev_reg !== want.dev_reg)
        report_mismatch($sformatf("pa %06h device_register exp %0d got %0d",
                                  want.pa, want.dev_reg, got.dev_reg));
      if (got.fwd_data !== want.fwd_data)
        report_mismatch($sformatf("pa %06h forward_data exp %02h got %02h",
                                  want.pa, want.fwd_data, got.fwd_data));
      if (got.fwd_wr !== want.fwd_wr)
        report_mismatch($sformatf("pa %06h forward_is_write exp %0b got %0b",
                                  want.pa, want.fwd_wr, got.fwd_wr));
    endtask
  endclass

  access_scoreboard sb = new;

  banked_address_decoder_top uut (
    .clk_i                     (clk_i),
    .rst_ni                    (rst_ni),
    .backup_ram_enable_we_i    (backup_ram_enable_we_i),
    .backup_ram_enable_wdata_i (backup_ram_enable_wdata_i),
    .in_valid_i                (in_valid_i),
    .in_stall_o                (in_stall_o),
    .mode_i                    (mode_i),
    .logical_address_i         (logical_address_i),
    .write_data_i              (write_data_i),
    .page_slot_i               (page_slot_i),
    .out_valid_o               (out_valid_o),
    .out_stall_i               (out_stall_i),
    .read_data_o               (read_data_o),
    .target_o                  (target_o),
    .physical_address_o        (physical_address_o),
    .device_register_o         (device_register_o),
    .forward_data_o            (forward_data_o),
    .forward_is_write_o        (forward_is_write_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk_i) begin
    res_t observed;
    if (out_valid_o && !out_stall_i) begin
      observed.read_data = read_data_o;
      observed.target    = tgt_e'(target_o);
      observed.pa        = physical_address_o;
      observed.dev_reg   = device_register_o;
      observed.fwd_data  = forward_data_o;
      observed.fwd_wr    = forward_is_write_o;
      sb.check_result(observed);
    end
  end

  // The clearing pass after reset is the longest quiet stretch of a good run.
  initial begin
    stuck_cycles = 0;
    while (stuck_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck_cycles = 0;
      else stuck_cycles++;
    end
    $display("banked_address_decoder_top regression: fail");
    $finish;
  end

  task automatic send_access(mode_e m, logic [LA_W-1:0] la, logic [DATA_W-1:0] wd,
                             logic [SLOT_W-1:0] slot);
    in_valid_i        <= 1'b1;
    mode_i            <= m;
    logical_address_i <= la;
    write_data_i      <= wd;
    page_slot_i       <= slot;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_access(m, la, wd, slot);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_backup_enable(bit value);
    backup_ram_enable_we_i    <= 1'b1;
    backup_ram_enable_wdata_i <= value;
    @(posedge clk_i);
    backup_ram_enable_we_i <= 1'b0;
    sb.backup_enable = value;
  endtask

  // Page numbers lean toward the I/O page and the RAM pages, and RAM offsets
  // toward a small range so that reads find earlier writes.
  task automatic send_random_access();
    int              sel;
    logic [12:0]     offset;
    logic [PAGE_W-1:0] page;
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      sel = $urandom_range(0, 99);
      if (sel < 30) page = 8'hff;
      else if (sel < 55) page = 8'hf8 + 8'($urandom_range(0, 3));
      else if (sel < 70) page = 8'hf7;
      else if (sel < 85) page = 8'($urandom_range(0, 8'h7f));
      else page = 8'($urandom);
      send_access(MODE_PAGE, 16'($urandom), page, 3'($urandom));
    end else if (sel < 19) begin
      send_access(MODE_NOP, 16'($urandom), 8'($urandom), 3'($urandom));
    end else begin
      sel = $urandom_range(0, 99);
      if (sel < 35) offset = 13'($urandom);
      else if (sel < 70) offset = {3'($urandom), 10'($urandom_range(0, 15))};
      else offset = 13'($urandom_range(0, 63));
      send_access(($urandom_range(0, 1) != 0) ? MODE_WRITE : MODE_READ,
                  {3'($urandom), offset}, 8'($urandom), 3'($urandom));
    end
  endtask

  task automatic run_phase(int sender_pct, int receiver_pct, int hold_at, int pause_at);
    send_idle_pct = sender_pct;
    stall_pct     = receiver_pct;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i == hold_at) begin
        // The output side holds off while requests keep coming, so the
        // pipeline fills and pushes back on the input.
        fork
          begin
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk_i);
            hold_off <= 1'b0;
          end
        join_none
      end
      if (i == pause_at) wait_for_results();
      send_random_access();
    end
    wait_for_results();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    write_backup_enable(1'b1);

    // Reset page map: slots 0-6 point at the I/O page, slot 7 at ROM page 0.
    send_access(MODE_READ,  16'he000, 8'h00, 3'd0);
    send_access(MODE_READ,  16'h0000, 8'h00, 3'd0);
    send_access(MODE_WRITE, 16'h0001, 8'h3c, 3'd0);
    send_access(MODE_WRITE, 16'h0002, 8'ha5, 3'd0);
    send_access(MODE_READ,  16'h0404, 8'h00, 3'd0);
    send_access(MODE_READ,  16'h0403, 8'h00, 3'd0);
    send_access(MODE_WRITE, 16'h0406, 8'h11, 3'd0);
    send_access(MODE_WRITE, 16'h0400, 8'hff, 3'd0);
    send_access(MODE_READ,  16'h0800, 8'h00, 3'd0);
    send_access(MODE_WRITE, 16'h0801, 8'h22, 3'd0);
    send_access(MODE_WRITE, 16'h0c01, 8'h44, 3'd0);
    send_access(MODE_READ,  16'h0c01, 8'h00, 3'd0);
    send_access(MODE_WRITE, 16'h1000, 8'h00, 3'd0);
    send_access(MODE_READ,  16'h1401, 8'h00, 3'd0);
    send_access(MODE_WRITE, 16'h1403, 8'h77, 3'd0);
    send_access(MODE_READ,  16'h1fff, 8'h00, 3'd0);
    send_access(MODE_PAGE,  16'h0000, 8'hf8, 3'd1);
    send_access(MODE_WRITE, 16'h2000, 8'h5a, 3'd0);
    send_access(MODE_PAGE,  16'hffff, 8'hfb, 3'd2);
    send_access(MODE_READ,  16'h4000, 8'h00, 3'd0);
    send_access(MODE_PAGE,  16'h0000, 8'hf7, 3'd3);
    send_access(MODE_WRITE, 16'h7fff, 8'hc3, 3'd0);
    send_access(MODE_READ,  16'h7fff, 8'h00, 3'd0);
    send_access(MODE_PAGE,  16'h0000, 8'h80, 3'd4);
    send_access(MODE_READ,  16'h8000, 8'h00, 3'd0);
    send_access(MODE_PAGE,  16'h0000, 8'h7f, 3'd5);
    send_access(MODE_WRITE, 16'hbfff, 8'h81, 3'd0);
    send_access(MODE_NOP,   16'hffff, 8'hff, 3'd7);
    wait_for_results();

    run_phase(0, 0, 100, -1);
    write_backup_enable(1'b0);
    run_phase(71, 0, -1, -1);
    write_backup_enable(1'b1);
    run_phase(0, 71, -1, PHASE_ITEMS / 2);
    write_backup_enable(1'b0);
    run_phase(26, 26, -1, -1);

    $display("Checked %0d results: %0d reads, %0d writes, %0d page sets, %0d no-ops, %0d forwarded.",
             sb.n_checked, sb.n_reads, sb.n_writes, sb.n_pages, sb.n_nops, sb.n_forwarded);
    $display("Backup RAM toggled on and off over four handshake mixes, with one long output hold.");
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("banked_address_decoder_top regression: pass");
    end else begin
      $display("banked_address_decoder_top regression: fail");
    end
    $finish;
  end

endmodule
